[rtl/bae_pkg.sv]
`timescale 1ns / 1ps

package bae_pkg;

    localparam int SymW      = 5;
    localparam int PolyW     = 30;
    localparam int CharW     = 7;
    localparam int CfgDataW  = 64;
    localparam int CfgAddrW  = 4;
    localparam int LenW      = 4;
    localparam int IdxW      = 4;
    localparam int PrefixMax = 8;
    localparam int ChkSyms   = 6;
    localparam int GenCount  = 5;

    localparam logic [CfgDataW-1:0] PrefixTextReset = 64'd25204;
    localparam logic [LenW-1:0]     PrefixLenReset  = 4'd2;

    localparam logic [PolyW-1:0] GEN [GenCount] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    localparam logic [CharW-1:0] CHARSET [32] = '{
        7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
        7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
        7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
        7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
    };

    localparam logic [CharW-1:0] SEP_CHAR = 7'h31;

    typedef enum logic [1:0] {
        REG_PREFIX_TEXT   = 2'd0,
        REG_PREFIX_LENGTH = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_WAIT_FIRST,
        ST_PFX_HI,
        ST_PFX_LO,
        ST_PFX_EMIT,
        ST_DATA,
        ST_WAIT_MID,
        ST_ZERO_STEP,
        ST_CHK_EMIT
    } state_t;

    typedef enum logic [2:0] {
        POLY_HOLD,
        POLY_INIT,
        POLY_STEP,
        POLY_XOR_ONE,
        POLY_SHIFT
    } poly_op_t;

    typedef enum logic [1:0] {
        STEP_PFX_HI,
        STEP_ZERO,
        STEP_PFX_LO,
        STEP_DATA
    } step_sel_t;

    typedef enum logic [1:0] {
        CHAR_PFX,
        CHAR_SEP,
        CHAR_DATA,
        CHAR_CHK
    } char_sel_t;

    typedef struct packed {
        logic      load_in;
        poly_op_t  poly_op;
        step_sel_t step_sel;
        logic      idx_clr;
        logic      idx_inc;
        logic      emit;
        char_sel_t char_sel;
        logic      emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_at_plen;
        logic idx_at_last_chk;
        logic idx_at_chk_end;
        logic out_free;
        logic fin;
    } dp_status_t;

    function automatic logic [PolyW-1:0] poly_step(input logic [PolyW-1:0] chk,
                                                   input logic [SymW-1:0]  v);
        logic [PolyW-1:0]    r;
        logic [GenCount-1:0] top;
        top = chk[PolyW-1 -: GenCount];
        r   = {chk[PolyW-GenCount-1:0], v};
        for (int j = 0; j < GenCount; j++) begin
            if (top[j]) begin
                r = r ^ GEN[j];
            end
        end
        return r;
    endfunction

endpackage

[rtl/bae_cfg.sv]
`timescale 1ns / 1ps

module bae_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bae_pkg::CfgAddrW-1:0]  paddr,
    input  logic [bae_pkg::CfgDataW-1:0]  pwdata,
    output logic [bae_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    output logic [bae_pkg::CfgDataW-1:0]  prefix_text,
    output logic [bae_pkg::LenW-1:0]      prefix_length
);

    logic [bae_pkg::CfgDataW-1:0] text_reg;
    logic [bae_pkg::LenW-1:0]     len_reg;
    bae_pkg::reg_idx_t            idx;
    logic                         wr_en;

    // registers sit on 8-byte boundaries, low address bits ignored
    assign idx   = paddr[3] ? bae_pkg::REG_PREFIX_LENGTH : bae_pkg::REG_PREFIX_TEXT;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_reg <= bae_pkg::PrefixTextReset;
            len_reg  <= bae_pkg::PrefixLenReset;
        end else if (wr_en) begin
            unique case (idx)
                bae_pkg::REG_PREFIX_TEXT:   text_reg <= pwdata;
                bae_pkg::REG_PREFIX_LENGTH: len_reg  <= pwdata[bae_pkg::LenW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bae_pkg::REG_PREFIX_LENGTH:
                prdata = {{(bae_pkg::CfgDataW-bae_pkg::LenW){1'b0}}, len_reg};
            default: prdata = text_reg;
        endcase
    end

    assign pready        = 1'b1;
    assign prefix_text   = text_reg;
    assign prefix_length = len_reg;

endmodule

[rtl/bae_dp.sv]
`timescale 1ns / 1ps

module bae_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bae_pkg::ctrl_cmd_t            cmd,
    output bae_pkg::dp_status_t           status,
    input  logic [bae_pkg::CfgDataW-1:0]  prefix_text,
    input  logic [bae_pkg::LenW-1:0]      prefix_length,
    input  logic [bae_pkg::SymW-1:0]      in_value,
    input  logic                          in_final,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bae_pkg::CharW-1:0]     out_char,
    output logic                          out_end
);

    logic [bae_pkg::PolyW-1:0] poly_reg, poly_next;
    logic [bae_pkg::SymW-1:0]  sym_reg;
    logic                      fin_reg;
    logic [bae_pkg::IdxW-1:0]  idx_reg, idx_next;
    logic                      ovalid_reg, ovalid_next;
    logic [bae_pkg::CharW-1:0] ochar_reg;
    logic                      oend_reg;

    logic [bae_pkg::LenW-1:0]  plen;
    logic [7:0]                pfx_byte;
    logic [bae_pkg::SymW-1:0]  step_val;
    logic [bae_pkg::CharW-1:0] char_val;

    assign plen = (prefix_length > bae_pkg::LenW'(bae_pkg::PrefixMax))
                  ? bae_pkg::LenW'(bae_pkg::PrefixMax) : prefix_length;

    assign pfx_byte = prefix_text[8*idx_reg[2:0] +: 8];

    always_comb begin
        case (cmd.step_sel)
            bae_pkg::STEP_PFX_HI: step_val = {2'b00, pfx_byte[7:5]};
            bae_pkg::STEP_PFX_LO: step_val = pfx_byte[4:0];
            bae_pkg::STEP_DATA:   step_val = sym_reg;
            default:              step_val = '0;
        endcase
    end

    always_comb begin
        case (cmd.char_sel)
            bae_pkg::CHAR_PFX:  char_val = pfx_byte[6:0];
            bae_pkg::CHAR_SEP:  char_val = bae_pkg::SEP_CHAR;
            bae_pkg::CHAR_DATA: char_val = bae_pkg::CHARSET[sym_reg];
            default:
                char_val = bae_pkg::CHARSET[poly_reg[bae_pkg::PolyW-1 -: bae_pkg::SymW]];
        endcase
    end

    always_comb begin
        case (cmd.poly_op)
            bae_pkg::POLY_INIT:    poly_next = bae_pkg::PolyW'(1);
            bae_pkg::POLY_STEP:    poly_next = bae_pkg::poly_step(poly_reg, step_val);
            bae_pkg::POLY_XOR_ONE: poly_next = poly_reg ^ bae_pkg::PolyW'(1);
            bae_pkg::POLY_SHIFT:   poly_next = {poly_reg[bae_pkg::PolyW-bae_pkg::SymW-1:0],
                                                {bae_pkg::SymW{1'b0}}};
            default:               poly_next = poly_reg;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg && !out_ready;
        if (cmd.emit) begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            poly_reg   <= bae_pkg::PolyW'(1);
        end else begin
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
            poly_reg   <= poly_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sym_reg <= in_value;
            fin_reg <= in_final;
        end
        if (cmd.emit) begin
            ochar_reg <= char_val;
            oend_reg  <= cmd.emit_last;
        end
    end

    assign status.idx_at_plen     = (idx_reg == plen);
    assign status.idx_at_last_chk = (idx_reg == bae_pkg::IdxW'(bae_pkg::ChkSyms - 1));
    assign status.idx_at_chk_end  = (idx_reg == bae_pkg::IdxW'(bae_pkg::ChkSyms));
    assign status.out_free        = !ovalid_reg || out_ready;
    assign status.fin             = fin_reg;

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_end   = oend_reg;

endmodule

[rtl/bae_ctrl.sv]
`timescale 1ns / 1ps

module bae_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bae_pkg::dp_status_t  status,
    output bae_pkg::ctrl_cmd_t   cmd
);

    bae_pkg::state_t state_reg, state_next;
    logic            accept;

    assign in_ready = (state_reg == bae_pkg::ST_WAIT_FIRST) ||
                      (state_reg == bae_pkg::ST_WAIT_MID);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bae_pkg::ST_WAIT_FIRST: begin
                if (accept) begin
                    state_next = bae_pkg::ST_PFX_HI;
                end
            end
            bae_pkg::ST_PFX_HI: begin
                if (status.idx_at_plen) begin
                    state_next = bae_pkg::ST_PFX_LO;
                end
            end
            bae_pkg::ST_PFX_LO: begin
                if (status.idx_at_plen) begin
                    state_next = bae_pkg::ST_PFX_EMIT;
                end
            end
            bae_pkg::ST_PFX_EMIT: begin
                if (status.out_free && status.idx_at_plen) begin
                    state_next = bae_pkg::ST_DATA;
                end
            end
            bae_pkg::ST_DATA: begin
                if (status.out_free) begin
                    state_next = status.fin ? bae_pkg::ST_ZERO_STEP : bae_pkg::ST_WAIT_MID;
                end
            end
            bae_pkg::ST_WAIT_MID: begin
                if (accept) begin
                    state_next = bae_pkg::ST_DATA;
                end
            end
            bae_pkg::ST_ZERO_STEP: begin
                if (status.idx_at_chk_end) begin
                    state_next = bae_pkg::ST_CHK_EMIT;
                end
            end
            bae_pkg::ST_CHK_EMIT: begin
                if (status.out_free && status.idx_at_last_chk) begin
                    state_next = bae_pkg::ST_WAIT_FIRST;
                end
            end
            default: state_next = bae_pkg::ST_WAIT_FIRST;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.poly_op   = bae_pkg::POLY_HOLD;
        cmd.step_sel  = bae_pkg::STEP_ZERO;
        cmd.char_sel  = bae_pkg::CHAR_PFX;
        unique case (state_reg)
            bae_pkg::ST_WAIT_FIRST: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    cmd.poly_op = bae_pkg::POLY_INIT;
                    cmd.idx_clr = 1'b1;
                end
            end
            bae_pkg::ST_PFX_HI: begin
                cmd.poly_op = bae_pkg::POLY_STEP;
                if (status.idx_at_plen) begin
                    cmd.step_sel = bae_pkg::STEP_ZERO;
                    cmd.idx_clr  = 1'b1;
                end else begin
                    cmd.step_sel = bae_pkg::STEP_PFX_HI;
                    cmd.idx_inc  = 1'b1;
                end
            end
            bae_pkg::ST_PFX_LO: begin
                if (status.idx_at_plen) begin
                    cmd.idx_clr = 1'b1;
                end else begin
                    cmd.poly_op  = bae_pkg::POLY_STEP;
                    cmd.step_sel = bae_pkg::STEP_PFX_LO;
                    cmd.idx_inc  = 1'b1;
                end
            end
            bae_pkg::ST_PFX_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.idx_at_plen) begin
                        cmd.char_sel = bae_pkg::CHAR_SEP;
                    end else begin
                        cmd.char_sel = bae_pkg::CHAR_PFX;
                        cmd.idx_inc  = 1'b1;
                    end
                end
            end
            bae_pkg::ST_DATA: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = bae_pkg::CHAR_DATA;
                    cmd.poly_op  = bae_pkg::POLY_STEP;
                    cmd.step_sel = bae_pkg::STEP_DATA;
                    cmd.idx_clr  = 1'b1;
                end
            end
            bae_pkg::ST_WAIT_MID: begin
                cmd.load_in = accept;
            end
            bae_pkg::ST_ZERO_STEP: begin
                if (status.idx_at_chk_end) begin
                    cmd.poly_op = bae_pkg::POLY_XOR_ONE;
                    cmd.idx_clr = 1'b1;
                end else begin
                    cmd.poly_op  = bae_pkg::POLY_STEP;
                    cmd.step_sel = bae_pkg::STEP_ZERO;
                    cmd.idx_inc  = 1'b1;
                end
            end
            bae_pkg::ST_CHK_EMIT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.char_sel  = bae_pkg::CHAR_CHK;
                    cmd.emit_last = status.idx_at_last_chk;
                    cmd.idx_inc   = 1'b1;
                    cmd.poly_op   = status.idx_at_last_chk ? bae_pkg::POLY_INIT
                                                           : bae_pkg::POLY_SHIFT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bae_pkg::ST_WAIT_FIRST;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/bech32_address_encoder.sv]
`timescale 1ns / 1ps

// bech32 string encoder: takes 5-bit data symbols, one string per run closed by tlast,
// and streams out the prefix, the '1' separator, one charset character per symbol and
// the six checksum characters (tlast on the last one). the polymod unit does one step
// per cycle and the controller handles one item at a time: the first symbol of a
// string also folds the prefix (prefix length capped at 8) and sends it, and the
// last symbol adds six zero steps and six checksum characters. every character waits on
// m_axis_tready. prefix text sits at byte address 0 and prefix length at 8; write them
// between strings
module bech32_address_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bae_pkg::CfgAddrW-1:0]  paddr,
    input  logic [bae_pkg::CfgDataW-1:0]  pwdata,
    output logic [bae_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [4:0] data_value
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [6:0] out_char
    output logic                          m_axis_tlast
);

    logic [bae_pkg::CfgDataW-1:0] prefix_text;
    logic [bae_pkg::LenW-1:0]     prefix_length;
    bae_pkg::ctrl_cmd_t           cmd;
    bae_pkg::dp_status_t          status;
    logic [bae_pkg::CharW-1:0]    out_char;

    bae_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .prefix_text   (prefix_text),
        .prefix_length (prefix_length)
    );

    bae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bae_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .prefix_text   (prefix_text),
        .prefix_length (prefix_length),
        .in_value      (s_axis_tdata[bae_pkg::SymW-1:0]),
        .in_final      (s_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_char      (out_char),
        .out_end       (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

[rtl/bae_checker.sv]
`timescale 1ns / 1ps

module bae_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [bae_pkg::CfgAddrW-1:0]  paddr,
    input logic [bae_pkg::CfgDataW-1:0]  pwdata,
    input logic [bae_pkg::CfgDataW-1:0]  prdata,
    input logic                          pready,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [7:0]                    s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [7:0]                    m_axis_tdata,
    input logic                          m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // no result pending straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one item at a time: never ready the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // accepting a non-final item is never followed by a newly valid end-of-string character
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !m_axis_tlast || !m_axis_tvalid
            || !$rose(m_axis_tvalid))
        else $error("end of string without final item");

endmodule

bind bech32_address_encoder bae_checker u_bae_checker (.*);

[verif/bech32_stream_checker.sv]
`timescale 1ns / 1ps

module bech32_stream_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bae_pkg::CfgAddrW-1:0] paddr,
    input  logic [bae_pkg::CfgDataW-1:0] pwdata,
    input  logic                         pready,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [7:0]                   m_axis_tdata,
    input  logic                         m_axis_tlast,
    input  logic                         run_done,
    output int                           mismatches,
    output int                           chars_pending,
    output int                           chars_checked
);

    import bae_pkg::*;

    localparam logic [PolyW-1:0] POLY_GEN [GenCount] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };
    localparam logic [255:0] BECH_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [CharW-1:0] SEPARATOR = 7'h31;
    localparam logic [CfgDataW-1:0] TEXT_AT_RESET = 64'd25204;
    localparam logic [LenW-1:0] LEN_AT_RESET = 4'd2;
    localparam logic [CfgAddrW-1:0] TEXT_ADDR = CfgAddrW'(8 * int'(REG_PREFIX_TEXT));
    localparam logic [CfgAddrW-1:0] LEN_ADDR = CfgAddrW'(8 * int'(REG_PREFIX_LENGTH));

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             eos;
    } enc_char_t;

    enc_char_t         expected_chars [$];
    logic [CfgDataW-1:0] cfg_text;
    logic [LenW-1:0]   cfg_len;
    logic [PolyW-1:0]  poly;
    logic              in_str;
    logic              leftovers_done;
    int                err_count;
    int                checked_count;

    function automatic logic [PolyW-1:0] bech_fold(input logic [PolyW-1:0] acc,
                                                   input logic [SymW-1:0]  sym);
        logic [PolyW-1:0]    nxt;
        logic [GenCount-1:0] top;
        top = acc[PolyW-1 -: GenCount];
        nxt = {acc[PolyW-GenCount-1:0], sym};
        for (int j = 0; j < GenCount; j++) begin
            if (top[j]) begin
                nxt = nxt ^ POLY_GEN[j];
            end
        end
        return nxt;
    endfunction

    function automatic logic [CharW-1:0] bech_char(input logic [SymW-1:0] sym);
        return BECH_ALPHABET[8 * (31 - int'(sym)) +: CharW];
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic encode_symbol(input logic [SymW-1:0] dv, input logic fin);
        int               plen;
        logic [PolyW-1:0] chk;
        if (!in_str) begin
            plen = (cfg_len > LenW'(PrefixMax)) ? PrefixMax : int'(cfg_len);
            poly = PolyW'(1);
            for (int i = 0; i < plen; i++) begin
                poly = bech_fold(poly, {2'b00, cfg_text[8 * i + 5 +: 3]});
            end
            poly = bech_fold(poly, SymW'(0));
            for (int i = 0; i < plen; i++) begin
                poly = bech_fold(poly, cfg_text[8 * i +: SymW]);
            end
            for (int i = 0; i < plen; i++) begin
                expected_chars.push_back({cfg_text[8 * i +: CharW], 1'b0});
            end
            expected_chars.push_back({SEPARATOR, 1'b0});
            in_str = 1'b1;
        end
        poly = bech_fold(poly, dv);
        expected_chars.push_back({bech_char(dv), 1'b0});
        if (fin) begin
            chk = poly;
            for (int i = 0; i < ChkSyms; i++) begin
                chk = bech_fold(chk, SymW'(0));
            end
            chk = chk ^ PolyW'(1);
            for (int i = 0; i < ChkSyms; i++) begin
                expected_chars.push_back({bech_char(chk[SymW * (ChkSyms - 1 - i) +: SymW]),
                                          i == ChkSyms - 1});
            end
            poly = PolyW'(1);
            in_str = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        enc_char_t want;
        if (!aresetn) begin
            cfg_text = TEXT_AT_RESET;
            cfg_len = LEN_AT_RESET;
            poly = PolyW'(1);
            in_str = 1'b0;
            leftovers_done = 1'b0;
            err_count = 0;
            checked_count = 0;
            expected_chars.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == TEXT_ADDR) begin
                    cfg_text = pwdata;
                end else if (paddr == LEN_ADDR) begin
                    cfg_len = pwdata[LenW-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                encode_symbol(s_axis_tdata[SymW-1:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                checked_count++;
                if (expected_chars.size() == 0) begin
                    flag_mismatch("unexpected character", int'(m_axis_tdata[CharW-1:0]), 0);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata[CharW-1:0] != want.ch) begin
                        flag_mismatch("out_char", int'(m_axis_tdata[CharW-1:0]), int'(want.ch));
                    end
                    if (m_axis_tlast != want.eos) begin
                        flag_mismatch("end_of_string", int'(m_axis_tlast), int'(want.eos));
                    end
                end
            end
            if (run_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                while (expected_chars.size() != 0) begin
                    want = expected_chars.pop_front();
                    flag_mismatch("character never sent", 0, int'(want.ch));
                end
            end
        end
        mismatches <= err_count;
        chars_pending <= expected_chars.size();
        chars_checked <= checked_count;
    end

endmodule

[verif/bech32_address_encoder_tb.sv]
`timescale 1ns / 1ps

module bech32_address_encoder_tb;

    import bae_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_SYMBOLS = 100;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_PATTERN
    } rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CfgAddrW-1:0]   paddr = '0;
    logic [CfgDataW-1:0]   pwdata = '0;
    logic [CfgDataW-1:0]   prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;  // [4:0] data_value
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;       // [6:0] out_char
    logic                  m_axis_tlast;
    logic                  run_done = 1'b0;

    int       mismatches;
    int       chars_pending;
    int       chars_checked;
    int       burst_left = 0;
    int       symbols_sent = 0;
    int       strings_sent = 0;
    int       settings_used = 0;
    int       quiet_cycles = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_span = 0;
    logic [7:0] rx_pattern = 8'hff;

    bech32_address_encoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bech32_stream_checker u_stream_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .run_done      (run_done),
        .mismatches    (mismatches),
        .chars_pending (chars_pending),
        .chars_checked (chars_checked)
    );

    always #6 aclk = ~aclk;

    // receiver stalls: modes held for random spans
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_span <= 0;
        end else begin
            if (rx_span == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_span <= $urandom_range(10, 60);
                rx_pattern <= 8'($urandom_range(1, 255));
            end else begin
                rx_span <= rx_span - 1;
                rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
            end
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SLOW:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: m_axis_tready <= rx_pattern[7];
                default:    m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("bech32_address_encoder verification failed");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CfgAddrW'(8 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_prefix(input logic [CfgDataW-1:0] text, input logic [LenW-1:0] len);
        write_reg(REG_PREFIX_TEXT, text);
        write_reg(REG_PREFIX_LENGTH, CfgDataW'(len));
        settings_used++;
    endtask

    task automatic push_symbol(input logic [SymW-1:0] dv, input logic fin);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, dv};
        s_axis_tlast <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        symbols_sent++;
        if (fin) begin
            strings_sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (chars_pending != 0);
    endtask

    task automatic send_random_string(input int len);
        for (int i = 0; i < len; i++) begin
            push_symbol(SymW'($urandom_range(0, 31)), i == len - 1);
        end
    endtask

    initial begin
        int random_count;
        int len;
        logic [LenW-1:0] plen;
        random_count = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // prefix left at reset value
        push_symbol(5'd0, 1'b1);
        push_symbol(5'd31, 1'b0);
        push_symbol(5'd21, 1'b0);
        push_symbol(5'd10, 1'b1);
        wait_drained();

        // length above eight, all bytes above 127
        set_prefix({CfgDataW{1'b1}}, 4'd15);
        push_symbol(5'd31, 1'b1);
        push_symbol(5'd0, 1'b0);
        push_symbol(5'd31, 1'b1);
        wait_drained();

        // empty prefix
        set_prefix('0, 4'd0);
        push_symbol(5'd5, 1'b0);
        push_symbol(5'd26, 1'b1);
        push_symbol(5'd0, 1'b1);
        wait_drained();

        set_prefix(64'h807f_4120_c03f_e11e, 4'd8);
        push_symbol(5'd1, 1'b0);
        push_symbol(5'd2, 1'b0);
        push_symbol(5'd4, 1'b0);
        push_symbol(5'd8, 1'b0);
        push_symbol(5'd16, 1'b1);
        wait_drained();

        set_prefix(64'h61, 4'd1);
        push_symbol(5'd17, 1'b0);
        push_symbol(5'd14, 1'b1);
        wait_drained();

        while (random_count < RANDOM_SYMBOLS) begin
            if ($urandom_range(0, 5) == 0) begin
                plen = ($urandom_range(0, 1) == 0) ? 4'd0 : LenW'($urandom_range(9, 15));
            end else begin
                plen = LenW'($urandom_range(1, 8));
            end
            set_prefix({$urandom, $urandom}, plen);
            repeat ($urandom_range(2, 5)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 6);
                send_random_string(len);
                random_count += len;
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        run_done <= 1'b1;
        repeat (3) @(posedge aclk);
        $display("covered %0d symbols in %0d strings across %0d prefix settings",
                 symbols_sent, strings_sent, settings_used + 1);
        $display("%0d output characters compared, %0d mismatches", chars_checked, mismatches);
        if (mismatches == 0) begin
            $display("bech32_address_encoder verification clean");
        end else begin
            $display("bech32_address_encoder verification failed");
        end
        $finish;
    end

endmodule
